### rtl/core/sphere_triangle_subdivider_macros.svh
// ----------------------------------------------------------------------------
// Sphere triangle subdivider assertion macros
// Shared concurrent assertion forms on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef SPHERE_TRIANGLE_SUBDIVIDER_MACROS_SVH
`define SPHERE_TRIANGLE_SUBDIVIDER_MACROS_SVH

// Same-cycle implication.
`define STSUB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STSUB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/stsub_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsub_pkg
// Register map, vertex stack slot codes and slot selection tables.
// ----------------------------------------------------------------------------
package stsub_pkg;

  localparam int SLOTS = 6;
  localparam int LEVELS_W = 2;
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_LEVELS_ADDR = 3'd0;

  // Per-level stack slots: the corners A, B, C, then the edge midpoints MA, MB, MC.
  typedef enum logic [2:0] {
    SLOT_A  = 3'd0,
    SLOT_B  = 3'd1,
    SLOT_C  = 3'd2,
    SLOT_MA = 3'd3,
    SLOT_MB = 3'd4,
    SLOT_MC = 3'd5
  } slot_t;

  // Corner j of child k: (A,B',C'), (B,C',A'), (C,A',B'), (B',A',C').
  function automatic slot_t child_slot(input logic [1:0] k, input logic [1:0] j);
    slot_t s;
    s = SLOT_A;
    unique case (k)
      2'd0: begin
        unique case (j)
          2'd0:    s = SLOT_A;
          2'd1:    s = SLOT_MB;
          default: s = SLOT_MC;
        endcase
      end
      2'd1: begin
        unique case (j)
          2'd0:    s = SLOT_B;
          2'd1:    s = SLOT_MC;
          default: s = SLOT_MA;
        endcase
      end
      2'd2: begin
        unique case (j)
          2'd0:    s = SLOT_C;
          2'd1:    s = SLOT_MA;
          default: s = SLOT_MB;
        endcase
      end
      default: begin
        unique case (j)
          2'd0:    s = SLOT_MB;
          2'd1:    s = SLOT_MA;
          default: s = SLOT_MC;
        endcase
      end
    endcase
    return s;
  endfunction

  // Midpoint j spans the edge opposite corner j.
  function automatic slot_t mid_p_slot(input logic [1:0] j);
    slot_t s;
    unique case (j)
      2'd0:    s = SLOT_B;
      2'd1:    s = SLOT_C;
      default: s = SLOT_A;
    endcase
    return s;
  endfunction

  function automatic slot_t mid_q_slot(input logic [1:0] j);
    slot_t s;
    unique case (j)
      2'd0:    s = SLOT_C;
      2'd1:    s = SLOT_A;
      default: s = SLOT_B;
    endcase
    return s;
  endfunction

  function automatic slot_t mid_dst_slot(input logic [1:0] j);
    slot_t s;
    unique case (j)
      2'd0:    s = SLOT_MA;
      2'd1:    s = SLOT_MB;
      default: s = SLOT_MC;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/stsub_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsub channel interfaces
// Triangle input channel and leaf triangle output channel.
// ----------------------------------------------------------------------------
interface stsub_tri_if #(parameter int COORD_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] in_a_x, in_a_y, in_a_z;
  logic signed [COORD_WIDTH-1:0] in_b_x, in_b_y, in_b_z;
  logic signed [COORD_WIDTH-1:0] in_c_x, in_c_y, in_c_z;

  modport source (output valid, in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z,
                  in_c_x, in_c_y, in_c_z, input ready);
  modport sink (input valid, in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z,
                in_c_x, in_c_y, in_c_z, output ready);
endinterface

interface stsub_leaf_if #(parameter int COORD_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] out_a_x, out_a_y, out_a_z;
  logic signed [COORD_WIDTH-1:0] out_b_x, out_b_y, out_b_z;
  logic signed [COORD_WIDTH-1:0] out_c_x, out_c_y, out_c_z;
  logic last_leaf;

  modport source (output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                  out_c_x, out_c_y, out_c_z, last_leaf, input ready);
  modport sink (input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                out_c_x, out_c_y, out_c_z, last_leaf, output ready);
endinterface

### rtl/core/stsub_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsub_front
// Accepts triangles, fixes the subdivision depth and queues them as jobs.
// ----------------------------------------------------------------------------
module stsub_front #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_LEVELS  = 3
) (
  input  logic                                   clk,
  input  logic                                   rst,
  stsub_tri_if.sink                              tri_ch,
  input  logic [stsub_pkg::LEVELS_W-1:0]         levels,
  output logic                                   job_valid,
  input  logic                                   job_ready,
  output logic [9*COORD_WIDTH-1:0]               job_tri,
  output logic [$clog2(MAX_LEVELS+1)-1:0]        job_depth
);

  localparam int LVW = $clog2(MAX_LEVELS + 1);
  localparam int QDEPTH = 2;
  localparam int PW = $clog2(QDEPTH);

  logic [9*COORD_WIDTH-1:0] q_tri [QDEPTH];
  logic [LVW-1:0]           q_depth [QDEPTH];
  logic [PW-1:0]            wr_ptr;
  logic [PW-1:0]            rd_ptr;
  logic [PW:0]              count;
  logic                     push;
  logic                     pop;
  logic [LVW-1:0]           depth_in;

  // Depth beyond the supported range saturates.
  assign depth_in = (levels > stsub_pkg::LEVELS_W'(MAX_LEVELS)) ? LVW'(MAX_LEVELS)
                                                               : LVW'(levels);

  assign tri_ch.ready = (count != (PW+1)'(QDEPTH));
  assign push         = tri_ch.valid && tri_ch.ready;
  assign job_valid    = (count != '0);
  assign pop          = job_valid && job_ready;
  assign job_tri      = q_tri[rd_ptr];
  assign job_depth    = q_depth[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        q_tri[wr_ptr]   <= {tri_ch.in_c_z, tri_ch.in_c_y, tri_ch.in_c_x,
                            tri_ch.in_b_z, tri_ch.in_b_y, tri_ch.in_b_x,
                            tri_ch.in_a_z, tri_ch.in_a_y, tri_ch.in_a_x};
        q_depth[wr_ptr] <= depth_in;
        wr_ptr          <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

### rtl/core/stsub_mid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsub_mid
// Edge midpoint projected onto the unit sphere: sum of squares, bit-serial
// square root, then one restoring division per component; a zero-length sum is halved instead.
// ----------------------------------------------------------------------------
module stsub_mid #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [3*COORD_WIDTH-1:0] p,
  input  logic [3*COORD_WIDTH-1:0] q,
  output logic                     done,
  output logic [3*COORD_WIDTH-1:0] m
);

  localparam int CW   = COORD_WIDTH;
  localparam int F    = CW - 2;
  localparam int R    = (CW > 16) ? CW - 16 : 0;
  localparam int AW   = CW + 1 - R;
  localparam int SW   = 2 * AW + 2;
  localparam int RW   = SW + 28;
  localparam int NW   = RW / 2;
  localparam int NUMW = AW + F + 15;
  localparam int QW   = CW;
  localparam int CNTW = $clog2(NW);

  typedef enum logic [2:0] {
    M_IDLE, M_ABS, M_SQ, M_CHK, M_SQRT, M_DLOAD, M_DIV, M_DSTORE
  } state_t;

  state_t                state;
  logic signed [CW:0]    sv [3];
  logic [AW-1:0]         av [3];
  logic [SW-1:0]         ssum;
  logic [RW-1:0]         rad;
  logic [NW:0]           srem;
  logic [NW-1:0]         root;
  logic [NW-1:0]         drem;
  logic [QW-1:0]         dlo;
  logic [1:0]            idx;
  logic [CNTW-1:0]       cnt;
  logic [CW-1:0]         res [3];

  logic [2*AW-1:0]       sq;
  logic [NW+1:0]         rem_t;
  logic [NW+1:0]         trial;
  logic                  s_ge;
  logic [NUMW-1:0]       num;
  logic [NW:0]           dt;
  logic                  d_ge;
  logic signed [CW+1:0]  sval;
  logic [CW:0]           mag [3];
  logic signed [CW:0]    half [3];

  localparam logic signed [CW+1:0] HI = (CW+2)'((1 << (CW - 1)) - 1);
  localparam logic signed [CW+1:0] LO = -HI - (CW+2)'(1);

  always_comb begin
    sq    = av[idx] * av[idx];
    rem_t = {srem[NW-1:0], rad[RW-1 -: 2]};
    trial = {root, 2'b01};
    s_ge  = (rem_t >= trial);
    num   = (NUMW'(av[idx]) << (F + 14)) + NUMW'(root[NW-1:1]);
    dt    = {drem, dlo[QW-1]};
    d_ge  = (dt >= {1'b0, root});
    sval  = sv[idx][CW] ? -$signed({2'b00, dlo}) : $signed({2'b00, dlo});
    for (int i = 0; i < 3; i++) begin
      mag[i]  = sv[i][CW] ? (CW+1)'(-sv[i]) : (CW+1)'(sv[i]);
      // Zero length: halve, rounding toward zero.
      half[i] = (sv[i] + $signed({{CW{1'b0}}, sv[i][CW]})) >>> 1;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_out
    assign m[g*CW +: CW] = res[g];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      done <= (state == M_CHK && ssum == '0) || (state == M_DSTORE && idx == 2'd2);
      unique case (state)
        M_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              sv[i] <= $signed({p[i*CW+CW-1], p[i*CW +: CW]})
                     + $signed({q[i*CW+CW-1], q[i*CW +: CW]});
            end
            state <= M_ABS;
          end
        end
        M_ABS: begin
          for (int i = 0; i < 3; i++) begin
            av[i] <= AW'(mag[i] >> R);
          end
          ssum  <= '0;
          idx   <= '0;
          state <= M_SQ;
        end
        M_SQ: begin
          ssum <= ssum + SW'(sq);
          if (idx == 2'd2) begin
            idx   <= '0;
            state <= M_CHK;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        M_CHK: begin
          if (ssum == '0) begin
            for (int i = 0; i < 3; i++) begin
              res[i] <= half[i][CW-1:0];
            end
            state <= M_IDLE;
          end else begin
            rad   <= RW'(ssum) << 28;
            srem  <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= M_SQRT;
          end
        end
        M_SQRT: begin
          rad <= rad << 2;
          if (s_ge) begin
            srem <= (NW+1)'(rem_t - trial);
            root <= {root[NW-2:0], 1'b1};
          end else begin
            srem <= (NW+1)'(rem_t);
            root <= {root[NW-2:0], 1'b0};
          end
          if (cnt == CNTW'(NW - 1)) begin
            idx   <= '0;
            state <= M_DLOAD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        M_DLOAD: begin
          drem  <= NW'(num >> QW);
          dlo   <= num[QW-1:0];
          cnt   <= '0;
          state <= M_DIV;
        end
        M_DIV: begin
          drem <= d_ge ? NW'(dt - {1'b0, root}) : NW'(dt);
          dlo  <= {dlo[QW-2:0], d_ge};
          if (cnt == CNTW'(QW - 1)) begin
            state <= M_DSTORE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        M_DSTORE: begin
          if (sval > HI) begin
            res[idx] <= HI[CW-1:0];
          end else if (sval < LO) begin
            res[idx] <= LO[CW-1:0];
          end else begin
            res[idx] <= sval[CW-1:0];
          end
          if (idx == 2'd2) begin
            state <= M_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= M_DLOAD;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/stsub_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsub_back
// Depth-first walk over the subdivision tree on a vertex stack memory,
// driving the midpoint unit and the leaf output register.
// ----------------------------------------------------------------------------
`include "sphere_triangle_subdivider_macros.svh"

module stsub_back #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_LEVELS  = 3
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   job_valid,
  output logic                                   job_ready,
  input  logic [9*COORD_WIDTH-1:0]               job_tri,
  input  logic [$clog2(MAX_LEVELS+1)-1:0]        job_depth,
  output logic                                   mid_start,
  output logic [3*COORD_WIDTH-1:0]               mid_p,
  output logic [3*COORD_WIDTH-1:0]               mid_q,
  input  logic                                   mid_done,
  input  logic [3*COORD_WIDTH-1:0]               mid_m,
  stsub_leaf_if.source                           leaf_ch
);

  localparam int CW    = COORD_WIDTH;
  localparam int VW    = 3 * CW;
  localparam int LVW   = $clog2(MAX_LEVELS + 1);
  localparam int DEPTH = (MAX_LEVELS + 1) * stsub_pkg::SLOTS;
  localparam int MAW   = $clog2(DEPTH);

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_NODE, B_MID_P, B_MID_Q, B_MID_GO, B_MID_WAIT,
    B_CH_RD, B_CH_WR, B_LF_RD, B_LF_CAP, B_EMIT, B_POP
  } state_t;

  function automatic logic [MAW-1:0] slot_addr(input logic [LVW-1:0] lvl,
                                               input stsub_pkg::slot_t s);
    return MAW'(int'(lvl) * stsub_pkg::SLOTS + int'(s));
  endfunction

  logic [VW-1:0]     mem [DEPTH];
  logic [VW-1:0]     rdata;
  logic              wr_en;
  logic [MAW-1:0]    wr_addr;
  logic [VW-1:0]     wr_data;
  logic              rd_en;
  logic [MAW-1:0]    rd_addr;

  state_t            state;
  logic [LVW-1:0]    cur;
  logic [LVW-1:0]    cur_m1;
  logic [LVW-1:0]    depth;
  logic [1:0]        j;
  logic [1:0]        child_idx [MAX_LEVELS+1];
  logic [9*CW-1:0]   item;
  logic [VW-1:0]     p_vec;
  logic [VW-1:0]     leaf [3];
  logic [VW-1:0]     out_v [3];
  logic              out_valid;
  logic              out_last;
  logic              emit_ok;
  logic              last_flag;
  stsub_pkg::slot_t  j_slot;

  assign cur_m1    = cur - 1'b1;
  assign emit_ok   = !out_valid || leaf_ch.ready;
  assign job_ready = (state == B_IDLE);
  assign mid_start = (state == B_MID_GO);
  assign mid_p     = p_vec;
  assign mid_q     = rdata;
  assign j_slot    = stsub_pkg::slot_t'({1'b0, j});

  // Last leaf: every ancestor is on its fourth child.
  always_comb begin
    last_flag = 1'b1;
    for (int d = 0; d < MAX_LEVELS; d++) begin
      if (LVW'(d) < cur && child_idx[d] != 2'd3) begin
        last_flag = 1'b0;
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rdata;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      B_LOAD: begin
        wr_en   = 1'b1;
        wr_addr = slot_addr('0, j_slot);
        wr_data = item[j*VW +: VW];
      end
      B_MID_P: begin
        rd_en   = 1'b1;
        rd_addr = slot_addr(cur, stsub_pkg::mid_p_slot(j));
      end
      B_MID_Q: begin
        rd_en   = 1'b1;
        rd_addr = slot_addr(cur, stsub_pkg::mid_q_slot(j));
      end
      B_MID_WAIT: begin
        wr_en   = mid_done;
        wr_addr = slot_addr(cur, stsub_pkg::mid_dst_slot(j));
        wr_data = mid_m;
      end
      B_CH_RD: begin
        rd_en   = 1'b1;
        rd_addr = slot_addr(cur, stsub_pkg::child_slot(child_idx[cur], j));
      end
      B_CH_WR: begin
        wr_en   = 1'b1;
        wr_addr = slot_addr(cur + 1'b1, j_slot);
      end
      B_LF_RD: begin
        rd_en   = 1'b1;
        rd_addr = slot_addr(cur, j_slot);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cur       <= '0;
      depth     <= '0;
      j         <= '0;
      out_valid <= 1'b0;
      for (int d = 0; d <= MAX_LEVELS; d++) begin
        child_idx[d] <= '0;
      end
    end else begin
      if (leaf_ch.ready && !(state == B_EMIT && emit_ok)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            item  <= job_tri;
            depth <= job_depth;
            j     <= '0;
            state <= B_LOAD;
          end
        end
        B_LOAD: begin
          if (j == 2'd2) begin
            j     <= '0;
            cur   <= '0;
            state <= B_NODE;
          end else begin
            j <= j + 1'b1;
          end
        end
        B_NODE: begin
          j     <= '0;
          state <= (cur == depth) ? B_LF_RD : B_MID_P;
        end
        B_MID_P: state <= B_MID_Q;
        B_MID_Q: begin
          p_vec <= rdata;
          state <= B_MID_GO;
        end
        B_MID_GO: state <= B_MID_WAIT;
        B_MID_WAIT: begin
          if (mid_done) begin
            if (j == 2'd2) begin
              j              <= '0;
              child_idx[cur] <= '0;
              state          <= B_CH_RD;
            end else begin
              j     <= j + 1'b1;
              state <= B_MID_P;
            end
          end
        end
        B_CH_RD: state <= B_CH_WR;
        B_CH_WR: begin
          if (j == 2'd2) begin
            j     <= '0;
            cur   <= cur + 1'b1;
            state <= B_NODE;
          end else begin
            j     <= j + 1'b1;
            state <= B_CH_RD;
          end
        end
        B_LF_RD: state <= B_LF_CAP;
        B_LF_CAP: begin
          leaf[j] <= rdata;
          if (j == 2'd2) begin
            state <= B_EMIT;
          end else begin
            j     <= j + 1'b1;
            state <= B_LF_RD;
          end
        end
        B_EMIT: begin
          if (emit_ok) begin
            out_v     <= leaf;
            out_last  <= last_flag;
            out_valid <= 1'b1;
            state     <= B_POP;
          end
        end
        B_POP: begin
          // At the root, finish; else climb to the parent and advance to its next child or keep climbing.
          if (cur == '0) begin
            state <= B_IDLE;
          end else if (child_idx[cur_m1] == 2'd3) begin
            cur <= cur_m1;
          end else begin
            child_idx[cur_m1] <= child_idx[cur_m1] + 1'b1;
            cur               <= cur_m1;
            j                 <= '0;
            state             <= B_CH_RD;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign leaf_ch.valid     = out_valid;
  assign leaf_ch.last_leaf = out_last;
  assign leaf_ch.out_a_x   = out_v[0][0*CW +: CW];
  assign leaf_ch.out_a_y   = out_v[0][1*CW +: CW];
  assign leaf_ch.out_a_z   = out_v[0][2*CW +: CW];
  assign leaf_ch.out_b_x   = out_v[1][0*CW +: CW];
  assign leaf_ch.out_b_y   = out_v[1][1*CW +: CW];
  assign leaf_ch.out_b_z   = out_v[1][2*CW +: CW];
  assign leaf_ch.out_c_x   = out_v[2][0*CW +: CW];
  assign leaf_ch.out_c_y   = out_v[2][1*CW +: CW];
  assign leaf_ch.out_c_z   = out_v[2][2*CW +: CW];

  `STSUB_ASSERT_IMPL(a_cur_in_range, state != B_IDLE, cur <= depth, "walk level past depth")
  `STSUB_ASSERT_IMPL(a_mid_done_wait, mid_done, state == B_MID_WAIT, "stray midpoint result")
  `STSUB_ASSERT_NEXT(a_emit_loads, state == B_EMIT && emit_ok, out_valid && state == B_POP, "leaf not loaded")

endmodule

### rtl/core/sphere_triangle_subdivider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_triangle_subdivider
// Icosphere midpoint subdivision of one triangle into 4^levels leaves.
// ----------------------------------------------------------------------------
// A triangle taken on tri_ch is split 'levels' times (saturated to MAX_LEVELS);
// leaves leave on leaf_ch depth first, the final one flagged by last_leaf.
// Triangles queue in a two-entry job queue while the walker works. The walk
// is serial over one midpoint unit: each midpoint takes a bit-serial square
// root of NW = COORD_WIDTH-R+16 bits (R = max(0,COORD_WIDTH-16)), then a
// restoring division of QW = COORD_WIDTH bits per component. L levels need 4^L-1
// midpoints, plus child setup per split node, leaf reads and output per leaf
// (held while leaf_ch is not ready), unwinding per tree node and loading of
// the triangle. The user must write the levels register (APB offset 0) only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivider #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_LEVELS  = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  stsub_tri_if.sink                        tri_ch,
  stsub_leaf_if.source                     leaf_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stsub_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int LVW = $clog2(MAX_LEVELS + 1);

  logic [stsub_pkg::LEVELS_W-1:0] levels;
  logic                           job_valid;
  logic                           job_ready;
  logic [9*COORD_WIDTH-1:0]       job_tri;
  logic [LVW-1:0]                 job_depth;
  logic                           mid_start;
  logic                           mid_done;
  logic [3*COORD_WIDTH-1:0]       mid_p;
  logic [3*COORD_WIDTH-1:0]       mid_q;
  logic [3*COORD_WIDTH-1:0]       mid_m;

  assign pready = 1'b1;
  assign prdata = (paddr == stsub_pkg::REG_LEVELS_ADDR) ? 32'(levels) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == stsub_pkg::REG_LEVELS_ADDR) begin
      levels <= pwdata[stsub_pkg::LEVELS_W-1:0];
    end
  end

  stsub_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAX_LEVELS  (MAX_LEVELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .tri_ch    (tri_ch),
    .levels    (levels),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_tri   (job_tri),
    .job_depth (job_depth)
  );

  stsub_mid #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mid (
    .clk   (clk),
    .rst   (rst),
    .start (mid_start),
    .p     (mid_p),
    .q     (mid_q),
    .done  (mid_done),
    .m     (mid_m)
  );

  stsub_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAX_LEVELS  (MAX_LEVELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_tri   (job_tri),
    .job_depth (job_depth),
    .mid_start (mid_start),
    .mid_p     (mid_p),
    .mid_q     (mid_q),
    .mid_done  (mid_done),
    .mid_m     (mid_m),
    .leaf_ch   (leaf_ch)
  );

endmodule

### tb/stsub_leaf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsub_leaf_checker
// Watches the triangle, leaf and register ports of the subdivider, computes
// the leaf triangles each accepted triangle must produce, and compares every
// leaf transaction against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module stsub_leaf_checker (
  input  logic        clk,
  input  logic        rst,
  stsub_tri_if        tri_ch,
  stsub_leaf_if       leaf_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [stsub_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          leaves_seen
);

  localparam int MAX_DEPTH = 3;

  typedef logic signed [15:0] vec_t [0:2];
  typedef struct {
    vec_t a;
    vec_t b;
    vec_t c;
    logic last;
  } leaf_t;

  leaf_t leaf_q[$];
  logic [stsub_pkg::LEVELS_W-1:0] levels_shadow;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Edge midpoint pushed back onto the unit sphere; a zero-length sum is halved.
  function automatic vec_t sphere_mid(vec_t p, vec_t q);
    longint sum [0:2];
    longint unsigned mag [0:2];
    longint unsigned ss, n, v;
    longint sv;
    vec_t m;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      sum[i] = longint'(p[i]) + longint'(q[i]);
      mag[i] = (sum[i] < 0) ? longint'(-sum[i]) : sum[i];
      ss += mag[i] * mag[i];
    end
    if (ss == 0) begin
      for (int i = 0; i < 3; i++) m[i] = 16'(sum[i] / 2);
      return m;
    end
    n = int_sqrt(ss << 28);
    for (int i = 0; i < 3; i++) begin
      v = ((mag[i] << 28) + n / 2) / n;
      sv = (sum[i] < 0) ? -longint'(v) : longint'(v);
      if (sv > 32767) sv = 32767;
      if (sv < -32768) sv = -32768;
      m[i] = 16'(sv);
    end
    return m;
  endfunction

  function automatic void split_tri(vec_t a, vec_t b, vec_t c, int depth);
    vec_t ma, mb, mc;
    leaf_t lf;
    if (depth == 0) begin
      lf.a = a;
      lf.b = b;
      lf.c = c;
      lf.last = 1'b0;
      leaf_q = {leaf_q, lf};
      return;
    end
    ma = sphere_mid(b, c);
    mb = sphere_mid(c, a);
    mc = sphere_mid(a, b);
    split_tri(a, mb, mc, depth - 1);
    split_tri(b, mc, ma, depth - 1);
    split_tri(c, ma, mb, depth - 1);
    split_tri(mb, ma, mc, depth - 1);
  endfunction

  function automatic logic [144:0] leaf_bits(leaf_t l);
    return {l.a[0], l.a[1], l.a[2], l.b[0], l.b[1], l.b[2],
            l.c[0], l.c[1], l.c[2], l.last};
  endfunction

  function automatic void report(string what, logic [144:0] exp_v, logic [144:0] act_v);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch %s: expected %h actual %h", $realtime, what, exp_v, act_v);
  endfunction

  assign pending = leaf_q.size();

  always @(posedge clk) begin
    leaf_t got, want;
    vec_t ta, tb_v, tc;
    int depth;
    if (rst) begin
      levels_shadow <= '0;
      leaf_q.delete();
    end else begin
      if (leaf_ch.valid && leaf_ch.ready) begin
        got.a = '{leaf_ch.out_a_x, leaf_ch.out_a_y, leaf_ch.out_a_z};
        got.b = '{leaf_ch.out_b_x, leaf_ch.out_b_y, leaf_ch.out_b_z};
        got.c = '{leaf_ch.out_c_x, leaf_ch.out_c_y, leaf_ch.out_c_z};
        got.last = leaf_ch.last_leaf;
        leaves_seen++;
        if (leaf_q.size() == 0) begin
          report("unexpected leaf", '0, leaf_bits(got));
        end else begin
          want = leaf_q.pop_front();
          if (leaf_bits(got) !== leaf_bits(want))
            report("leaf", leaf_bits(want), leaf_bits(got));
        end
      end
      if (tri_ch.valid && tri_ch.ready) begin
        ta = '{tri_ch.in_a_x, tri_ch.in_a_y, tri_ch.in_a_z};
        tb_v = '{tri_ch.in_b_x, tri_ch.in_b_y, tri_ch.in_b_z};
        tc = '{tri_ch.in_c_x, tri_ch.in_c_y, tri_ch.in_c_z};
        depth = (levels_shadow > MAX_DEPTH) ? MAX_DEPTH : levels_shadow;
        split_tri(ta, tb_v, tc, depth);
        leaf_q[leaf_q.size() - 1].last = 1'b1;
      end
      if (psel && penable && pready && paddr == stsub_pkg::REG_LEVELS_ADDR) begin
        if (pwrite)
          levels_shadow <= pwdata[stsub_pkg::LEVELS_W-1:0];
        else if (prdata[stsub_pkg::LEVELS_W-1:0] !== levels_shadow)
          report("levels readback", 145'(levels_shadow),
                 145'(prdata[stsub_pkg::LEVELS_W-1:0]));
      end
    end
  end

  initial begin
    errors = 0;
    leaves_seen = 0;
  end
endmodule

### tb/sphere_triangle_subdivider_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_triangle_subdivider_tb
// Drives triangles and levels settings into the subdivider with random
// backpressure; a separate checker predicts and compares every leaf.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivider_tb;

  localparam logic [stsub_pkg::PADDR_W-1:0] REG_UNMAPPED_ADDR = 3'd4;

  typedef logic signed [15:0] vec_t [0:2];

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [stsub_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  int errors, pending, leaves_seen;
  int src_idle, snk_idle;
  int sent;

  stsub_tri_if #(.COORD_WIDTH(16)) tri_ch ();
  stsub_leaf_if #(.COORD_WIDTH(16)) leaf_ch ();

  sphere_triangle_subdivider #(.COORD_WIDTH(16), .MAX_LEVELS(3)) u_dut (
    .clk(clk), .rst(rst), .tri_ch(tri_ch), .leaf_ch(leaf_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  stsub_leaf_checker u_checker (
    .clk(clk), .rst(rst), .tri_ch(tri_ch), .leaf_ch(leaf_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(errors), .pending(pending), .leaves_seen(leaves_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    leaf_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  task automatic reg_access(input logic wr, input logic [stsub_pkg::PADDR_W-1:0] addr,
                            input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain all outstanding leaves before touching the register.
  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_levels(input int lv);
    wait_idle();
    reg_access(1'b1, stsub_pkg::REG_LEVELS_ADDR, {$urandom} & ~32'h3 | 32'(lv));
    reg_access(1'b0, stsub_pkg::REG_LEVELS_ADDR, '0);
  endtask

  task automatic send_tri(input vec_t a, input vec_t b, input vec_t c);
    while ($urandom_range(99) < src_idle) begin
      @(negedge clk);
      tri_ch.valid <= 1'b0;
    end
    @(negedge clk);
    tri_ch.valid <= 1'b1;
    tri_ch.in_a_x <= a[0]; tri_ch.in_a_y <= a[1]; tri_ch.in_a_z <= a[2];
    tri_ch.in_b_x <= b[0]; tri_ch.in_b_y <= b[1]; tri_ch.in_b_z <= b[2];
    tri_ch.in_c_x <= c[0]; tri_ch.in_c_y <= c[1]; tri_ch.in_c_z <= c[2];
    do @(posedge clk); while (!tri_ch.ready);
    sent++;
  endtask

  function automatic vec_t rand_vec(input int mode);
    vec_t v;
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0:       v[i] = 16'($urandom);
        1:       v[i] = 16'($urandom_range(32768) - 16384);
        default: v[i] = 16'($urandom_range(6) - 3);
      endcase
    end
    return v;
  endfunction

  task automatic send_random(input int n);
    vec_t a, b, c;
    int shape;
    for (int k = 0; k < n; k++) begin
      shape = $urandom_range(9);
      a = rand_vec(shape < 3 ? 0 : (shape < 8 ? 1 : 2));
      b = rand_vec(shape < 3 ? 0 : (shape < 8 ? 1 : 2));
      c = rand_vec(shape < 3 ? 0 : (shape < 8 ? 1 : 2));
      // Opposite corners give a zero-length edge sum.
      if (shape == 9) begin
        for (int i = 0; i < 3; i++) b[i] = -a[i];
      end
      send_tri(a, b, c);
    end
    @(negedge clk);
    tri_ch.valid <= 1'b0;
  endtask

  task automatic send_directed();
    send_tri('{16384, 0, 0}, '{0, 16384, 0}, '{0, 0, 16384});
    send_tri('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
    send_tri('{32767, 32767, 32767}, '{32767, 32767, 32767}, '{-32768, -32768, -32768});
    send_tri('{-32768, -32768, -32768}, '{-32768, 32767, 0}, '{32767, -32768, 1});
    send_tri('{16384, -5, 3}, '{-16384, 5, -3}, '{1, -1, 1});
    send_tri('{1, 0, 0}, '{0, 0, 0}, '{0, -1, 0});
    @(negedge clk);
    tri_ch.valid <= 1'b0;
  endtask

  initial begin
    int idle_pairs [0:2][0:1];
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    tri_ch.valid = 1'b0;
    tri_ch.in_a_x = '0; tri_ch.in_a_y = '0; tri_ch.in_a_z = '0;
    tri_ch.in_b_x = '0; tri_ch.in_b_y = '0; tri_ch.in_b_z = '0;
    tri_ch.in_c_x = '0; tri_ch.in_c_y = '0; tri_ch.in_c_z = '0;
    leaf_ch.ready = 1'b0;
    sent = 0;
    idle_pairs = '{'{13, 61}, '{61, 13}, '{0, 0}};
    src_idle = 13;
    snk_idle = 61;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset value of levels is zero: pass-through.
    send_directed();
    set_levels(1);
    send_directed();
    set_levels(3);
    send_directed();
    // Writes to an unmapped offset must leave levels alone.
    wait_idle();
    reg_access(1'b1, REG_UNMAPPED_ADDR, 32'h0);
    send_random(2);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = idle_pairs[ph][0];
      snk_idle = idle_pairs[ph][1];
      set_levels(0);
      send_random(40);
      set_levels(1);
      send_random(40);
      set_levels(2);
      send_random(28);
      set_levels(3);
      send_random(8);
    end

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d triangles over levels 0..3 and three backpressure mixes;", sent);
    $display("checked %0d leaf triangles and the levels readback.", leaves_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
